@@ src/ctlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlt_pkg: shared types and constants
// Field widths, command codes and the structs passed between the stages.
// ----------------------------------------------------------------------------
package ctlt_pkg;

  localparam int ID_W    = 32;
  localparam int COORD_W = 16;
  localparam int RETRY_W = 8;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int NORM_W  = SQ_W + 2;

  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(5);

  localparam logic CMD_TRACK   = 1'b0;
  localparam logic CMD_ACQUIRE = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic                      present;
    logic [ID_W-1:0]           target_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last;
  } det_t;

  typedef struct packed {
    det_t            det;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
  } sq_item_t;

  typedef struct packed {
    logic                      ok;
    logic [ID_W-1:0]           out_id;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      coasted;
    logic                      is_locked;
  } res_t;

endpackage

@@ src/ctlt_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlt_ifs: channel interfaces
// Detection input, track result output and retry limit write channel.
// ----------------------------------------------------------------------------
interface ctlt_det_if import ctlt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic                      present;
  logic [ID_W-1:0]           target_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      last;

  modport source (output valid, cmd, present, target_id, pos_x, pos_y, pos_z, last,
                  input ready);
  modport sink (input valid, cmd, present, target_id, pos_x, pos_y, pos_z, last,
                output ready);
endinterface

interface ctlt_res_if import ctlt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [ID_W-1:0]           out_id;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      coasted;
  logic                      is_locked;

  modport source (output valid, ok, out_id, out_x, out_y, out_z, coasted, is_locked,
                  input ready);
  modport sink (input valid, ok, out_id, out_x, out_y, out_z, coasted, is_locked,
                output ready);
endinterface

interface ctlt_cfg_if import ctlt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RETRY_W-1:0] max_retries;

  modport source (output valid, max_retries, input ready);
  modport sink (input valid, max_retries, output ready);
endinterface

@@ src/closest_target_lock_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_target_lock_tracker: nearest target lock with coast
// Flow: the last detection transfer of a frame loads the input register, and
// the result register loads from it once free; the result transfer follows.
// Throughput: one detection per cycle; squares ahead of the input register,
// sum, compare and lock update between it and the result register. A closing
// item waits in the input register while an untaken result is still held.
// Reset (rst, synchronous): unlocked, retry limit 5, frame empty, no result.
// ----------------------------------------------------------------------------
module closest_target_lock_tracker import ctlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ctlt_det_if.sink   det,
  ctlt_res_if.source res,
  ctlt_cfg_if.sink   cfg
);

  // Retry limit register; writes are always taken.
  logic [RETRY_W-1:0] max_retries;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= RETRY_RESET;
    end else if (cfg.valid) begin
      max_retries <= cfg.max_retries;
    end
  end

  // Stage 1: detection plus squared coordinates.
  det_t     det_in;
  sq_item_t s1;
  logic     s1_vld;
  logic     s1_fire;
  logic     det_take;

  // Result register.
  res_t res_q;
  res_t core_res;
  logic out_vld;
  logic out_free;

  assign det_in = '{cmd:       det.cmd,
                    present:   det.present,
                    target_id: det.target_id,
                    pos_x:     det.pos_x,
                    pos_y:     det.pos_y,
                    pos_z:     det.pos_z,
                    last:      det.last};

  // Only a frame-closing item needs room in the result register; the others
  // drain into the accumulator every cycle.
  assign out_free  = !out_vld || res.ready;
  assign s1_fire   = s1_vld && (!s1.det.last || out_free);
  assign det.ready = !s1_vld || s1_fire;
  assign det_take  = det.valid && det.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= det_take || (s1_vld && !s1_fire);
    end
  end

  ctlt_norm_stage u_norm (
    .clk    (clk),
    .load   (det_take),
    .det_in (det_in),
    .item   (s1)
  );

  // Stage 2: running minimum, locked id match, end of frame decision.
  ctlt_lock_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .item        (s1),
    .max_retries (max_retries),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (s1_fire && s1.det.last) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.det.last) begin
      res_q <= core_res;
    end
  end

  assign res.valid     = out_vld;
  assign res.ok        = res_q.ok;
  assign res.out_id    = res_q.out_id;
  assign res.out_x     = res_q.out_x;
  assign res.out_y     = res_q.out_y;
  assign res.out_z     = res_q.out_z;
  assign res.coasted   = res_q.coasted;
  assign res.is_locked = res_q.is_locked;

endmodule

@@ src/ctlt_norm_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlt_norm_stage: input register with coordinate squares
// Captures one detection and the three squared coordinates.
// ----------------------------------------------------------------------------
module ctlt_norm_stage import ctlt_pkg::*; (
  input  logic     clk,
  input  logic     load,
  input  det_t     det_in,
  output sq_item_t item
);

  logic signed [SQ_W-1:0] px;
  logic signed [SQ_W-1:0] py;
  logic signed [SQ_W-1:0] pz;

  always_comb begin
    px = SQ_W'(det_in.pos_x) * SQ_W'(det_in.pos_x);
    py = SQ_W'(det_in.pos_y) * SQ_W'(det_in.pos_y);
    pz = SQ_W'(det_in.pos_z) * SQ_W'(det_in.pos_z);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.det  <= det_in;
      item.sq_x <= $unsigned(px);
      item.sq_y <= $unsigned(py);
      item.sq_z <= $unsigned(pz);
    end
  end

endmodule

@@ src/ctlt_lock_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlt_lock_core: frame accumulator and lock state
// Running minimum norm, locked id search, and end of frame decision.
// ----------------------------------------------------------------------------
module ctlt_lock_core import ctlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  sq_item_t           item,
  input  logic [RETRY_W-1:0] max_retries,
  output res_t               res
);

  logic                      locked, locked_next;
  logic [ID_W-1:0]           locked_id, locked_id_next;
  logic [RETRY_W-1:0]        retry_count, retry_count_next;
  logic [ID_W-1:0]           held_id, held_id_next;
  logic signed [COORD_W-1:0] held_x, held_x_next;
  logic signed [COORD_W-1:0] held_y, held_y_next;
  logic signed [COORD_W-1:0] held_z, held_z_next;
  logic [NORM_W-1:0]         best_norm, best_norm_next;
  logic [ID_W-1:0]           best_id, best_id_next;
  logic signed [COORD_W-1:0] best_x, best_x_next;
  logic signed [COORD_W-1:0] best_y, best_y_next;
  logic signed [COORD_W-1:0] best_z, best_z_next;
  logic                      f_entry, f_entry_next;
  logic                      f_found, f_found_next;

  logic [NORM_W-1:0] norm;
  logic              take_best;
  logic              hit;

  always_comb begin
    norm = NORM_W'(item.sq_x) + NORM_W'(item.sq_y) + NORM_W'(item.sq_z);
    take_best = item.det.present && (!f_entry || (norm < best_norm));
    hit = item.det.present && locked && (item.det.target_id == locked_id) && !f_found;

    locked_next      = locked;
    locked_id_next   = locked_id;
    retry_count_next = retry_count;
    held_id_next     = hit ? locked_id : held_id;
    held_x_next      = hit ? item.det.pos_x : held_x;
    held_y_next      = hit ? item.det.pos_y : held_y;
    held_z_next      = hit ? item.det.pos_z : held_z;
    best_norm_next   = take_best ? norm : best_norm;
    best_id_next     = take_best ? item.det.target_id : best_id;
    best_x_next      = take_best ? item.det.pos_x : best_x;
    best_y_next      = take_best ? item.det.pos_y : best_y;
    best_z_next      = take_best ? item.det.pos_z : best_z;
    f_entry_next     = f_entry | item.det.present;
    f_found_next     = f_found | hit;

    res = '0;

    if (item.det.last) begin
      if (item.det.cmd == CMD_ACQUIRE) begin
        if (f_entry_next) begin
          locked_next      = 1'b1;
          locked_id_next   = best_id_next;
          held_id_next     = best_id_next;
          held_x_next      = best_x_next;
          held_y_next      = best_y_next;
          held_z_next      = best_z_next;
          retry_count_next = '0;
          res.ok           = 1'b1;
        end
      end else if (locked) begin
        if (f_found_next) begin
          retry_count_next = '0;
          res.ok           = 1'b1;
        end else if (retry_count < max_retries) begin
          retry_count_next = retry_count + RETRY_W'(1);
          res.ok           = 1'b1;
          res.coasted      = 1'b1;
        end else begin
          locked_next = 1'b0;
        end
      end
      if (res.ok) begin
        res.out_id = held_id_next;
        res.out_x  = held_x_next;
        res.out_y  = held_y_next;
        res.out_z  = held_z_next;
      end
      res.is_locked = locked_next;
      // frame closed: accumulators back to empty
      best_norm_next = '1;
      f_entry_next   = 1'b0;
      f_found_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked      <= 1'b0;
      locked_id   <= '0;
      retry_count <= '0;
      held_id     <= '0;
      held_x      <= '0;
      held_y      <= '0;
      held_z      <= '0;
      best_norm   <= '1;
      f_entry     <= 1'b0;
      f_found     <= 1'b0;
    end else if (step) begin
      locked      <= locked_next;
      locked_id   <= locked_id_next;
      retry_count <= retry_count_next;
      held_id     <= held_id_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      held_z      <= held_z_next;
      best_norm   <= best_norm_next;
      f_entry     <= f_entry_next;
      f_found     <= f_found_next;
    end
  end

  // candidate payload, only read while the entry flag is set
  always_ff @(posedge clk) begin
    if (step) begin
      best_id <= best_id_next;
      best_x  <= best_x_next;
      best_y  <= best_y_next;
      best_z  <= best_z_next;
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: closest_target_lock_tracker verification
// Streams frames of detections through the block with random gaps on the
// input side and random stalls on the result side. Every accepted transfer
// runs through a local lock/coast predictor, and each result transfer is
// checked field by field against the oldest expected report.
// ----------------------------------------------------------------------------
module testbench;
  import ctlt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctlt_det_if det_bus ();
  ctlt_res_if res_bus ();
  ctlt_cfg_if cfg_bus ();

  closest_target_lock_tracker dut (
    .clk (clk),
    .rst (rst),
    .det (det_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker predictor state: lock, coast counter, held vector and the running
  // minimum of the frame in progress.
  // --------------------------------------------------------------------------
  logic [RETRY_W-1:0]        retry_limit;
  logic                      trk_locked;
  logic [ID_W-1:0]           trk_locked_id;
  logic [RETRY_W-1:0]        trk_retries;
  logic [ID_W-1:0]           held_id;
  logic signed [COORD_W-1:0] held_x, held_y, held_z;
  logic [NORM_W-1:0]         best_norm;
  logic [ID_W-1:0]           best_id;
  logic signed [COORD_W-1:0] best_x, best_y, best_z;
  logic                      frame_has_entry;
  logic                      frame_found;

  det_t pending_dets[$];      // detections waiting for the driver
  res_t expected_reports[$];  // reports owed by the block, oldest first

  int mismatches = 0;
  int gap_odds   = 8;         // 0 turns off all idling
  int det_gap    = 0;
  int res_stall  = 0;
  bit det_taken  = 1'b0;
  logic [ID_W-1:0] id_pool[4];

  function automatic void clear_frame_acc();
    best_norm       = '1;
    best_id         = '0;
    best_x          = '0;
    best_y          = '0;
    best_z          = '0;
    frame_has_entry = 1'b0;
    frame_found     = 1'b0;
  endfunction

  // One accepted detection. On the closing item of a frame the report is
  // worked out and queued.
  function automatic void predict_tracker(det_t d);
    int px, py, pz;
    logic [NORM_W-1:0] n;
    res_t r;
    if (d.present) begin
      px = d.pos_x;
      py = d.pos_y;
      pz = d.pos_z;
      n = NORM_W'(px * px) + NORM_W'(py * py) + NORM_W'(pz * pz);
      // strict compare keeps the first detection on a tie
      if (!frame_has_entry || n < best_norm) begin
        best_norm = n;
        best_id   = d.target_id;
        best_x    = d.pos_x;
        best_y    = d.pos_y;
        best_z    = d.pos_z;
      end
      frame_has_entry = 1'b1;
      // duplicate locked id: only the first match updates the held vector
      if (trk_locked && d.target_id == trk_locked_id && !frame_found) begin
        frame_found = 1'b1;
        held_id     = trk_locked_id;
        held_x      = d.pos_x;
        held_y      = d.pos_y;
        held_z      = d.pos_z;
      end
    end
    if (!d.last) return;

    r = '0;
    // only the cmd of the closing item selects the mode
    if (d.cmd == CMD_ACQUIRE) begin
      if (frame_has_entry) begin
        trk_locked    = 1'b1;
        trk_locked_id = best_id;
        held_id       = best_id;
        held_x        = best_x;
        held_y        = best_y;
        held_z        = best_z;
        trk_retries   = '0;
        r.ok          = 1'b1;
      end
      // empty acquire frame: failure, state untouched
    end else if (!trk_locked) begin
      // track while unlocked: failure
    end else if (frame_found) begin
      trk_retries = '0;
      r.ok        = 1'b1;
    end else if (trk_retries < retry_limit) begin
      trk_retries = trk_retries + RETRY_W'(1);
      r.ok        = 1'b1;
      r.coasted   = 1'b1;
    end else begin
      trk_locked = 1'b0;
    end
    if (r.ok) begin
      r.out_id = held_id;
      r.out_x  = held_x;
      r.out_y  = held_y;
      r.out_z  = held_z;
    end
    r.is_locked = trk_locked;
    expected_reports.push_back(r);
    clear_frame_acc();
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    det_t d;
    res_t exp_r;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) retry_limit = cfg_bus.max_retries;

      if (det_bus.valid && det_bus.ready) begin
        det_taken   = 1'b1;
        d.cmd       = det_bus.cmd;
        d.present   = det_bus.present;
        d.target_id = det_bus.target_id;
        d.pos_x     = det_bus.pos_x;
        d.pos_y     = det_bus.pos_y;
        d.pos_z     = det_bus.pos_z;
        d.last      = det_bus.last;
        predict_tracker(d);
      end

      if (res_bus.valid && res_bus.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no report expected");
          mismatches++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("ok", 64'(exp_r.ok), 64'(res_bus.ok));
          check_field("out_id", 64'(exp_r.out_id), 64'(res_bus.out_id));
          check_field("out_x", 64'(exp_r.out_x), 64'(res_bus.out_x));
          check_field("out_y", 64'(exp_r.out_y), 64'(res_bus.out_y));
          check_field("out_z", 64'(exp_r.out_z), 64'(res_bus.out_z));
          check_field("coasted", 64'(exp_r.coasted), 64'(res_bus.coasted));
          check_field("is_locked", 64'(exp_r.is_locked), 64'(res_bus.is_locked));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Detection driver: falling edge, random bursts of idle cycles between items.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    det_t cur;
    if (rst) begin
      det_bus.valid <= 1'b0;
    end else if (!det_bus.valid || det_taken) begin
      if (det_gap > 0) begin
        det_gap--;
        det_bus.valid <= 1'b0;
      end else if (pending_dets.size() == 0) begin
        det_bus.valid <= 1'b0;
      end else if (gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
        det_gap = $urandom_range(0, 8);
        det_bus.valid <= 1'b0;
      end else begin
        cur = pending_dets.pop_front();
        det_bus.valid     <= 1'b1;
        det_bus.cmd       <= cur.cmd;
        det_bus.present   <= cur.present;
        det_bus.target_id <= cur.target_id;
        det_bus.pos_x     <= cur.pos_x;
        det_bus.pos_y     <= cur.pos_y;
        det_bus.pos_z     <= cur.pos_z;
        det_bus.last      <= cur.last;
      end
    end
    det_taken = 1'b0;
  end

  // Result backpressure: random stall bursts.
  always @(negedge clk) begin
    if (res_stall > 0) begin
      res_stall--;
      res_bus.ready <= 1'b0;
    end else if (!rst && gap_odds > 0 && $urandom_range(0, gap_odds + 3) == 0) begin
      res_stall = $urandom_range(0, 8);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_det(input logic c, input logic p, input logic [ID_W-1:0] id,
                           input int x, input int y, input int z, input logic l);
    det_t d;
    d.cmd       = c;
    d.present   = p;
    d.target_id = id;
    d.pos_x     = COORD_W'(x);
    d.pos_y     = COORD_W'(y);
    d.pos_z     = COORD_W'(z);
    d.last      = l;
    pending_dets.push_back(d);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2, 3:    return int'($urandom_range(0, 12)) - 6;  // small: ties are common
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // One random frame; returns the number of items queued.
  task automatic queue_random_frame(output int counted);
    int kind, len, i;
    logic c, p, l, cmd_close;
    logic [ID_W-1:0] id;
    kind      = $urandom_range(0, 9);
    len       = (kind == 0) ? $urandom_range(1, 3) : $urandom_range(1, 6);
    cmd_close = (kind == 1 || kind == 2) ? CMD_ACQUIRE :
                (kind == 9) ? logic'($urandom_range(0, 1)) : CMD_TRACK;
    counted   = 0;
    for (i = 0; i < len; i++) begin
      l = (i == len - 1);
      c = l ? cmd_close : logic'($urandom_range(0, 1));
      case (kind)
        0:       p = 1'b0;                              // empty frame
        9:       p = logic'($urandom_range(0, 1));      // noise
        default: p = ($urandom_range(0, 7) != 0);
      endcase
      // kinds 6..8 and noise use ids that almost never match the lock
      id = (kind >= 6) ? ID_W'($urandom) : id_pool[$urandom_range(0, 3)];
      queue_det(c, p, id, rand_coord(), rand_coord(), rand_coord(), l);
      counted++;
    end
  endtask

  // Wait until every report is in and the pipeline has drained.
  task automatic settle_tracker();
    while (pending_dets.size() != 0 || det_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [RETRY_W-1:0] v);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.max_retries <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("closest_target_lock_tracker test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [RETRY_W-1:0] limits[7];
    int phase, got, n;

    det_bus.valid       = 1'b0;
    det_bus.cmd         = 1'b0;
    det_bus.present     = 1'b0;
    det_bus.target_id   = '0;
    det_bus.pos_x       = '0;
    det_bus.pos_y       = '0;
    det_bus.pos_z       = '0;
    det_bus.last        = 1'b0;
    res_bus.ready       = 1'b1;
    cfg_bus.valid       = 1'b0;
    cfg_bus.max_retries = '0;

    retry_limit   = RETRY_RESET;
    trk_locked    = 1'b0;
    trk_locked_id = '0;
    trk_retries   = '0;
    held_id       = '0;
    held_x        = '0;
    held_y        = '0;
    held_z        = '0;
    clear_frame_acc();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed frames, retry limit at its reset value ----
    // track while unlocked
    queue_det(CMD_TRACK, 1'b1, 32'hFFFF_FFFF, -32768, 32767, -32768, 1'b1);
    // empty acquire frame
    queue_det(CMD_ACQUIRE, 1'b0, 32'h0, 0, 0, 0, 1'b1);
    // acquire with a norm tie: 32'hA wins over 32'hB; mode taken from last item
    queue_det(CMD_TRACK, 1'b1, 32'hFFFF_FFFF, 32767, -32768, 0, 1'b0);
    queue_det(CMD_TRACK, 1'b1, 32'h0000_000A, 3, 4, 0, 1'b0);
    queue_det(CMD_ACQUIRE, 1'b1, 32'h0000_000B, 0, -5, 0, 1'b0);
    queue_det(CMD_ACQUIRE, 1'b0, 32'h0000_000A, -1, -1, -1, 1'b0);
    queue_det(CMD_ACQUIRE, 1'b1, 32'h0000_000C, -32768, -32768, -32768, 1'b1);
    // track found, duplicate locked id: first match wins
    queue_det(CMD_ACQUIRE, 1'b1, 32'h0000_000B, 0, 0, 0, 1'b0);
    queue_det(CMD_TRACK, 1'b1, 32'h0000_000A, 1, 2, 3, 1'b0);
    queue_det(CMD_TRACK, 1'b1, 32'h0000_000A, 7, 7, 7, 1'b0);
    queue_det(CMD_TRACK, 1'b0, 32'h0000_000A, 9, 9, 9, 1'b1);
    // acquire while locked: relock on id 0
    queue_det(CMD_ACQUIRE, 1'b1, 32'h0, -1, -1, -1, 1'b1);
    // locked id missing: coast five frames, then unlock
    repeat (6) queue_det(CMD_TRACK, 1'b1, 32'h0000_0005, 32767, 32767, 32767, 1'b1);
    // unlocked again
    queue_det(CMD_TRACK, 1'b1, 32'h0, 0, 0, 0, 1'b1);
    settle_tracker();

    // ---- random phases over a sweep of retry limits ----
    limits[0] = 8'd1;
    limits[1] = 8'd0;
    limits[2] = 8'd255;
    limits[3] = 8'd3;
    limits[4] = RETRY_W'($urandom_range(2, 254));
    limits[5] = 8'd5;
    limits[6] = 8'd2;
    for (phase = 0; phase < 7; phase++) begin
      write_retry_limit(limits[phase]);
      foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);
      gap_odds = (phase == 6) ? 0 : ((phase % 2) ? 16 : 4);
      got = 0;
      while (got < 205) begin
        queue_random_frame(n);
        got += n;
      end
      settle_tracker();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("closest_target_lock_tracker test passed");
    end else begin
      $display("closest_target_lock_tracker test failed");
    end
    $finish;
  end

endmodule
